FILE: rtl/ipbm_pkg.sv
package ipbm_pkg;

	localparam int HOST_SLOTS_DEF = 16;
	localparam int IPS_PER_HOST_DEF = 4;

	localparam int MAC_W = 48;
	localparam int PORT_W = 8;
	localparam int TIME_W = 32;
	localparam int PEND_W = 9;
	localparam int IP_W = 32;
	localparam int HROW_W = MAC_W + PORT_W + TIME_W + PEND_W;
	localparam int ENTRY_W = 2 * IP_W;
	localparam int MAX_IPS = 4;

	localparam logic [15:0] TIMEOUT_RST = 16'd60;
	localparam logic [7:0] CHECKS_RST = 8'd10;
	localparam logic REPORT_RST = 1'b1;

	localparam logic [1:0] CFG_TIMEOUT = 2'd0;
	localparam logic [1:0] CFG_CHECKS = 2'd1;
	localparam logic [1:0] CFG_REPORT = 2'd2;

	localparam logic KIND_PACKET = 1'b0;

	localparam logic [2:0] EV_REG = 3'd0;
	localparam logic [2:0] EV_IP = 3'd1;
	localparam logic [2:0] EV_CHK = 3'd2;
	localparam logic [2:0] EV_REL = 3'd3;
	localparam logic [2:0] EV_FULL = 3'd4;

	typedef struct packed {
		logic [2:0] ev;
		logic [MAC_W-1:0] mac;
		logic [PORT_W-1:0] port;
		logic [TIME_W-1:0] seen;
		logic [2:0] cnt;
		logic [MAX_IPS-1:0][IP_W-1:0] ips;
	} res_t;

endpackage

FILE: rtl/ipbm_ram.sv
module ipbm_ram #(
	parameter int W = 8,
	parameter int D = 16,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [W-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [W-1:0] rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/mac_ip_binding_monitor.sv
// channel  | valid     | stall     | payload
// input    | in_valid  | in_stall  | kind now mac port ip_present host_ip
// output   | out_valid | out_stall | event_res out_mac out_port out_seen ip_count ip_first..
// config   | cfg_we    | -         | cfg_index cfg_data
// one item at a time: a packet reads every host slot for lookup, then updates, with an
// address table step on a known host; a tick skips lookup and update
// aging then walks every slot, skipping an empty one and doing read, multiply and evaluate
// on an occupied one, and a final step closes the item
// the walks go slot by slot: the host and address table memories have a single read port
// reset empties both tables through per-slot valid flops, no clearing pass is needed
// a result waits in a hold register until the next one or the end of the item marks last
// out_stall holds aging when a second result has no room, and the close while one is held
module mac_ip_binding_monitor #(
	parameter int HOST_SLOTS = ipbm_pkg::HOST_SLOTS_DEF,
	parameter int IPS_PER_HOST = ipbm_pkg::IPS_PER_HOST_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic kind,
	input logic [31:0] now,
	input logic [47:0] mac,
	input logic [7:0] port,
	input logic ip_present,
	input logic [31:0] host_ip,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] event_res,
	output logic [47:0] out_mac,
	output logic [7:0] out_port,
	output logic [31:0] out_seen,
	output logic [2:0] ip_count,
	output logic [31:0] ip_first,
	output logic [31:0] ip_second,
	output logic [31:0] ip_third,
	output logic [31:0] ip_fourth,
	output logic last,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);

	localparam int SW = (HOST_SLOTS > 1) ? $clog2(HOST_SLOTS) : 1;
	localparam int CW = $clog2(HOST_SLOTS + 1);
	localparam int EW = ipbm_pkg::ENTRY_W;
	localparam int AROW_W = IPS_PER_HOST * EW;
	localparam int HW = ipbm_pkg::HROW_W;
	localparam int TW = ipbm_pkg::TIME_W;
	localparam int PW = ipbm_pkg::PEND_W;

	typedef enum logic [2:0] {
		S_IDLE, S_LOOK, S_PKT, S_ADDR, S_AG_RD, S_AG_MUL, S_AG_EVAL, S_FIN
	} state_t;

	state_t state_q;
	logic [CW-1:0] cnt_q;
	logic look_v_s1;
	logic [SW-1:0] idx_s1;
	logic hit_v_q, free_v_q;
	logic [SW-1:0] hit_q, free_q;

	logic ipp_q;
	logic [31:0] now_q, ip_q;
	logic [47:0] mac_q;
	logic [7:0] port_q;

	logic [15:0] timeout_q;
	logic [7:0] checks_q;
	logic report_q;
	logic [23:0] tc_q;
	logic [24:0] prod_q;

	logic [HOST_SLOTS-1:0] hv_q;
	logic [IPS_PER_HOST-1:0] av_q [HOST_SLOTS];

	logic [HW-1:0] h_rd, h_s2;
	logic [AROW_W-1:0] a_rd, a_s2;

	ipbm_pkg::res_t hold_q, out_q, push_res;
	logic hold_v_q, out_v_q, last_q;

	logic host_we, addr_we;
	logic [SW-1:0] host_wa, addr_wa, addr_ra;
	logic [HW-1:0] host_wd;
	logic [AROW_W-1:0] addr_wd;
	logic push_en, out_free, step_go, fin_pop;
	logic hv_we, hv_val;
	logic [SW-1:0] hv_idx;
	logic av_we;
	logic [IPS_PER_HOST-1:0] av_val;

	logic [SW-1:0] cidx;
	logic [47:0] h_mac;
	logic [7:0] h_port;
	logic [31:0] h_seen;
	logic [PW-1:0] h_pend, pn;
	logic expired, rel, need_push;
	logic match_f, free_f, stale_f;
	logic [IPS_PER_HOST-1:0] cur_v;
	logic [AROW_W-1:0] row_n;
	logic [IPS_PER_HOST-1:0] v_n;

	function automatic ipbm_pkg::res_t mk_res(input logic [2:0] ev, input logic [47:0] m,
		input logic [7:0] p, input logic [31:0] sn, input logic [AROW_W-1:0] row,
		input logic [IPS_PER_HOST-1:0] v);
		ipbm_pkg::res_t r;
		logic [2:0] c;
		r.ev = ev;
		r.mac = m;
		r.port = p;
		r.seen = sn;
		r.ips = '0;
		c = '0;
		for (int i = 0; i < IPS_PER_HOST; i++) begin
			if (v[i]) begin
				r.ips[c[1:0]] = row[i*EW +: 32];
				c = c + 3'd1;
			end
		end
		r.cnt = c;
		return r;
	endfunction

	assign cidx = cnt_q[SW-1:0];
	assign addr_ra = (state_q == S_PKT) ? hit_q : cidx;

	ipbm_ram #(.W(HW), .D(HOST_SLOTS), .AW(SW)) u_host_ram (
		.clk(clk), .we(host_we), .waddr(host_wa), .wdata(host_wd),
		.raddr(cidx), .rdata(h_rd)
	);

	ipbm_ram #(.W(AROW_W), .D(HOST_SLOTS), .AW(SW)) u_addr_ram (
		.clk(clk), .we(addr_we), .waddr(addr_wa), .wdata(addr_wd),
		.raddr(addr_ra), .rdata(a_rd)
	);

	assign out_free = !out_v_q || !out_stall;
	assign fin_pop = (state_q == S_FIN) && hold_v_q && out_free;
	assign {h_mac, h_port, h_seen, h_pend} = h_s2;
	assign pn = h_pend + 9'd1;
	assign expired = ({1'b0, h_seen} + {8'b0, prod_q}) < {1'b0, now_q};
	assign rel = expired && (pn >= ({1'b0, checks_q} + 9'd1));
	assign need_push = rel || (expired && report_q);

	always_comb begin
		host_we = 1'b0;
		host_wa = cidx;
		host_wd = {mac_q, port_q, now_q, 9'd1};
		addr_we = 1'b0;
		addr_wa = cidx;
		addr_wd = a_rd;
		push_en = 1'b0;
		push_res = mk_res(ipbm_pkg::EV_FULL, mac_q, port_q, now_q, a_rd, '0);
		step_go = 1'b0;
		hv_we = 1'b0;
		hv_idx = cidx;
		hv_val = 1'b0;
		av_we = 1'b0;
		av_val = '0;
		match_f = 1'b0;
		free_f = 1'b0;
		stale_f = 1'b0;
		cur_v = av_q[hit_q];
		row_n = a_rd;
		v_n = cur_v;
		case (state_q)
			S_PKT: begin
				if (hit_v_q) begin
					host_we = 1'b1;
					host_wa = hit_q;
				end else if (free_v_q) begin
					host_we = 1'b1;
					host_wa = free_q;
					hv_we = 1'b1;
					hv_idx = free_q;
					hv_val = 1'b1;
					av_we = 1'b1;
					v_n = '0;
					row_n = a_rd;
					if (ipp_q) begin
						v_n[0] = 1'b1;
						row_n[EW-1:0] = {now_q, ip_q};
						addr_we = 1'b1;
						addr_wa = free_q;
						addr_wd = row_n;
					end
					av_val = v_n;
					hv_idx = free_q;
					push_en = 1'b1;
					push_res = mk_res(ipbm_pkg::EV_REG, mac_q, port_q, now_q, row_n, v_n);
				end else begin
					push_en = 1'b1;
				end
			end
			S_ADDR: begin
				if (ipp_q) begin
					for (int i = 0; i < IPS_PER_HOST; i++) begin
						if (!match_f && cur_v[i] && a_rd[i*EW +: 32] == ip_q) begin
							match_f = 1'b1;
							row_n[i*EW+32 +: 32] = now_q;
						end
					end
					if (!match_f) begin
						for (int i = 0; i < IPS_PER_HOST; i++) begin
							if (!free_f && !cur_v[i]) begin
								free_f = 1'b1;
								row_n[i*EW +: EW] = {now_q, ip_q};
								v_n[i] = 1'b1;
							end
						end
					end
					addr_wa = hit_q;
					addr_we = match_f || free_f;
					addr_wd = row_n;
					av_we = free_f;
					av_val = v_n;
					hv_idx = hit_q;
					if (!match_f) begin
						push_en = 1'b1;
						push_res = mk_res(free_f ? ipbm_pkg::EV_IP : ipbm_pkg::EV_FULL,
							mac_q, port_q, now_q, row_n, v_n);
					end
				end
			end
			S_AG_EVAL: begin
				cur_v = av_q[cidx];
				v_n = cur_v;
				step_go = !need_push || !hold_v_q || out_free;
				push_en = need_push && step_go;
				push_res = mk_res(rel ? ipbm_pkg::EV_REL : ipbm_pkg::EV_CHK,
					h_mac, h_port, h_seen, a_s2, cur_v);
				if (step_go) begin
					if (rel) begin
						hv_we = 1'b1;
						hv_val = 1'b0;
						av_we = 1'b1;
						av_val = '0;
					end else begin
						host_we = expired;
						host_wd = {h_mac, h_port, h_seen, pn};
						for (int i = 0; i < IPS_PER_HOST; i++) begin
							if (!stale_f && cur_v[i] && ({1'b0, a_s2[i*EW+32 +: 32]} +
								{9'b0, tc_q}) < {1'b0, now_q}) begin
								stale_f = 1'b1;
								v_n[i] = 1'b0;
							end
						end
						av_we = stale_f;
						av_val = v_n;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			look_v_s1 <= 1'b0;
			hit_v_q <= 1'b0;
			free_v_q <= 1'b0;
			hv_q <= '0;
			for (int s = 0; s < HOST_SLOTS; s++) begin
				av_q[s] <= '0;
			end
			hold_v_q <= 1'b0;
			out_v_q <= 1'b0;
			timeout_q <= ipbm_pkg::TIMEOUT_RST;
			checks_q <= ipbm_pkg::CHECKS_RST;
			report_q <= ipbm_pkg::REPORT_RST;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ipbm_pkg::CFG_TIMEOUT: timeout_q <= cfg_data;
					ipbm_pkg::CFG_CHECKS: checks_q <= cfg_data[7:0];
					ipbm_pkg::CFG_REPORT: report_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (hv_we) begin
				hv_q[hv_idx] <= hv_val;
			end
			if (av_we) begin
				av_q[state_q == S_AG_EVAL ? cidx : hv_idx] <= av_val;
			end
			if (push_en && hold_v_q) begin
				out_q <= hold_q;
				last_q <= 1'b0;
				out_v_q <= 1'b1;
			end else if (fin_pop) begin
				out_q <= hold_q;
				last_q <= 1'b1;
				out_v_q <= 1'b1;
			end else if (out_v_q && !out_stall) begin
				out_v_q <= 1'b0;
			end
			if (push_en) begin
				hold_q <= push_res;
				hold_v_q <= 1'b1;
			end else if (fin_pop) begin
				hold_v_q <= 1'b0;
			end
			look_v_s1 <= (state_q == S_LOOK) && (cnt_q < CW'(HOST_SLOTS));
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						now_q <= now;
						mac_q <= mac;
						port_q <= port;
						ipp_q <= ip_present;
						ip_q <= host_ip;
						cnt_q <= '0;
						hit_v_q <= 1'b0;
						free_v_q <= 1'b0;
						state_q <= (kind == ipbm_pkg::KIND_PACKET) ? S_LOOK : S_AG_RD;
					end
				end
				S_LOOK: begin
					if (cnt_q < CW'(HOST_SLOTS)) begin
						idx_s1 <= cidx;
						cnt_q <= cnt_q + 1'b1;
					end else if (!look_v_s1) begin
						state_q <= S_PKT;
					end
					if (look_v_s1) begin
						if (hv_q[idx_s1]) begin
							if (!hit_v_q && h_rd[HW-1 -: 56] == {mac_q, port_q}) begin
								hit_v_q <= 1'b1;
								hit_q <= idx_s1;
							end
						end else if (!free_v_q) begin
							free_v_q <= 1'b1;
							free_q <= idx_s1;
						end
					end
				end
				S_PKT: begin
					cnt_q <= '0;
					state_q <= hit_v_q ? S_ADDR : S_AG_RD;
				end
				S_ADDR: begin
					state_q <= S_AG_RD;
				end
				S_AG_RD: begin
					tc_q <= timeout_q * checks_q;
					if (cnt_q == CW'(HOST_SLOTS)) begin
						state_q <= S_FIN;
					end else if (!hv_q[cidx]) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= S_AG_MUL;
					end
				end
				S_AG_MUL: begin
					h_s2 <= h_rd;
					a_s2 <= a_rd;
					prod_q <= timeout_q * h_rd[PW-1:0];
					state_q <= S_AG_EVAL;
				end
				S_AG_EVAL: begin
					if (step_go) begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= S_AG_RD;
					end
				end
				S_FIN: begin
					if (!hold_v_q || out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_v_q;
	assign event_res = out_q.ev;
	assign out_mac = out_q.mac;
	assign out_port = out_q.port;
	assign out_seen = out_q.seen;
	assign ip_count = out_q.cnt;
	assign ip_first = out_q.ips[0];
	assign ip_second = out_q.ips[1];
	assign ip_third = out_q.ips[2];
	assign ip_fourth = out_q.ips[3];
	assign last = last_q;

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !hold_v_q)
		else $error("result held while idle");

	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PKT && hit_v_q) |-> hv_q[hit_q])
		else $error("lookup hit on empty slot");

	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && !hold_v_q) |=> state_q == S_IDLE)
		else $error("item did not finish");

endmodule

FILE: tb/tb_mac_ip_binding_monitor.sv
module tb_mac_ip_binding_monitor;

	localparam int SLOTS = 16;
	localparam int IPS = 4;
	localparam logic KIND_TICK = ~ipbm_pkg::KIND_PACKET;

	typedef struct {
		logic [2:0] ev;
		logic [47:0] mac;
		logic [7:0] port;
		logic [31:0] seen;
		logic [2:0] cnt;
		logic [31:0] ips [IPS];
		logic fin;
	} binding_ev_t;

	class binding_scoreboard;
		logic [15:0] tmo;
		logic [7:0] checks;
		logic rep;
		bit hv [SLOTS];
		logic [47:0] hmac [SLOTS];
		logic [7:0] hport [SLOTS];
		logic [31:0] hseen [SLOTS];
		logic [8:0] hpend [SLOTS];
		bit av [SLOTS*IPS];
		logic [31:0] aval [SLOTS*IPS];
		logic [31:0] aseen [SLOTS*IPS];
		binding_ev_t events_due [$];
		int errors;

		function new();
			tmo = ipbm_pkg::TIMEOUT_RST;
			checks = ipbm_pkg::CHECKS_RST;
			rep = ipbm_pkg::REPORT_RST;
			errors = 0;
			foreach (hv[i]) hv[i] = 0;
			foreach (av[i]) av[i] = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				ipbm_pkg::CFG_TIMEOUT: tmo = val;
				ipbm_pkg::CFG_CHECKS: checks = val[7:0];
				ipbm_pkg::CFG_REPORT: rep = val[0];
				default: ;
			endcase
		endfunction

		function void push(logic [2:0] ev, logic [47:0] m, logic [7:0] p, logic [31:0] sn,
				int slot);
			binding_ev_t e;
			int c;
			c = 0;
			e.ev = ev;
			e.mac = m;
			e.port = p;
			e.seen = sn;
			e.fin = 0;
			foreach (e.ips[i]) e.ips[i] = '0;
			if (slot >= 0) begin
				for (int i = 0; i < IPS; i++) begin
					if (av[slot*IPS+i]) begin
						e.ips[c] = aval[slot*IPS+i];
						c++;
					end
				end
			end
			e.cnt = 3'(c);
			events_due.push_back(e);
		endfunction

		// 0 refreshed, 1 added, 2 list full
		function int add_addr(int s, logic [31:0] ip, logic [31:0] t);
			int fs;
			fs = -1;
			for (int i = 0; i < IPS; i++) begin
				if (av[s*IPS+i] && aval[s*IPS+i] == ip) begin
					aseen[s*IPS+i] = t;
					return 0;
				end
				if (!av[s*IPS+i] && fs < 0) fs = s*IPS + i;
			end
			if (fs < 0) return 2;
			av[fs] = 1;
			aval[fs] = ip;
			aseen[fs] = t;
			return 1;
		endfunction

		function void note(logic k, logic [31:0] t, logic [47:0] m, logic [7:0] p,
				logic ipp, logic [31:0] ip);
			int hit, fs, r, start;
			longint unsigned lim;
			start = events_due.size();
			hit = -1;
			fs = -1;
			if (k == ipbm_pkg::KIND_PACKET) begin
				for (int s = 0; s < SLOTS; s++) begin
					if (hv[s]) begin
						if (hit < 0 && hmac[s] == m && hport[s] == p) hit = s;
					end else if (fs < 0) fs = s;
				end
				if (hit >= 0) begin
					hseen[hit] = t;
					hpend[hit] = 1;
					if (ipp) begin
						r = add_addr(hit, ip, t);
						if (r == 1) push(ipbm_pkg::EV_IP, m, p, t, hit);
						else if (r == 2) push(ipbm_pkg::EV_FULL, m, p, t, hit);
					end
				end else if (fs >= 0) begin
					hv[fs] = 1;
					hmac[fs] = m;
					hport[fs] = p;
					hseen[fs] = t;
					hpend[fs] = 1;
					for (int i = 0; i < IPS; i++) av[fs*IPS+i] = 0;
					if (ipp) void'(add_addr(fs, ip, t));
					push(ipbm_pkg::EV_REG, m, p, t, fs);
				end else begin
					push(ipbm_pkg::EV_FULL, m, p, t, -1);
				end
			end
			for (int s = 0; s < SLOTS; s++) begin
				if (!hv[s]) continue;
				lim = longint'(hseen[s]) + longint'(tmo) * longint'(hpend[s]);
				if (lim < longint'(t)) begin
					hpend[s] = hpend[s] + 1;
					if ({23'd0, hpend[s]} >= {24'd0, checks} + 32'd1) begin
						push(ipbm_pkg::EV_REL, hmac[s], hport[s], hseen[s], s);
						hv[s] = 0;
						for (int i = 0; i < IPS; i++) av[s*IPS+i] = 0;
						continue;
					end
					if (rep) push(ipbm_pkg::EV_CHK, hmac[s], hport[s], hseen[s], s);
				end
				for (int i = 0; i < IPS; i++) begin
					if (av[s*IPS+i] && longint'(aseen[s*IPS+i]) +
							longint'(tmo) * longint'(checks) < longint'(t)) begin
						av[s*IPS+i] = 0;
						break;
					end
				end
			end
			if (events_due.size() > start) events_due[$].fin = 1;
		endfunction

		function void field(string nm, logic [63:0] e, logic [63:0] a);
			if (e !== a) begin
				$display("%0t %s expected %h actual %h", $time, nm, e, a);
				errors++;
			end
		endfunction

		function void check(binding_ev_t a);
			binding_ev_t e;
			if (events_due.size() == 0) begin
				$display("%0t unexpected result event %0d mac %h", $time, a.ev, a.mac);
				errors++;
				return;
			end
			e = events_due.pop_front();
			field("event_res", e.ev, a.ev);
			field("out_mac", e.mac, a.mac);
			field("out_port", e.port, a.port);
			field("out_seen", e.seen, a.seen);
			field("ip_count", e.cnt, a.cnt);
			field("ip_first", e.ips[0], a.ips[0]);
			field("ip_second", e.ips[1], a.ips[1]);
			field("ip_third", e.ips[2], a.ips[2]);
			field("ip_fourth", e.ips[3], a.ips[3]);
			field("last", e.fin, a.fin);
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, kind, ip_present;
	logic [31:0] now, host_ip;
	logic [47:0] mac;
	logic [7:0] port;
	logic out_valid, out_stall, last;
	logic [2:0] event_res, ip_count;
	logic [47:0] out_mac;
	logic [7:0] out_port;
	logic [31:0] out_seen, ip_first, ip_second, ip_third, ip_fourth;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	binding_scoreboard sb = new();
	bit quiet = 0;
	int cycle = 0;
	int hold_left = 0, burst_left = 0;
	logic [47:0] mac_pool [24];
	logic [31:0] ip_pool [12];
	logic [31:0] now_t;

	mac_ip_binding_monitor u_dut (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle == 2000) begin
			hold_left <= 400;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (burst_left > 0) begin
			burst_left <= burst_left - 1;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			burst_left <= $urandom_range(0, 6);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		binding_ev_t a;
		if (out_valid && !out_stall) begin
			a.ev = event_res;
			a.mac = out_mac;
			a.port = out_port;
			a.seen = out_seen;
			a.cnt = ip_count;
			a.ips[0] = ip_first;
			a.ips[1] = ip_second;
			a.ips[2] = ip_third;
			a.ips[3] = ip_fourth;
			a.fin = last;
			sb.check(a);
		end
	end

	task automatic send_item(logic k, logic [31:0] t, logic [47:0] m, logic [7:0] p,
			logic ipp, logic [31:0] ip);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		kind <= k;
		now <= t;
		mac <= m;
		port <= p;
		ip_present <= ipp;
		host_ip <= ip;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note(k, t, m, p, ipp, ip);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic settle_and_config(logic [15:0] to, logic [15:0] cc, logic [15:0] rp);
		in_valid <= 1'b0;
		while (sb.events_due.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		write_reg(ipbm_pkg::CFG_TIMEOUT, to);
		write_reg(ipbm_pkg::CFG_CHECKS, cc);
		write_reg(ipbm_pkg::CFG_REPORT, rp);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(int n, logic [15:0] to, logic [7:0] cc);
		int k;
		logic [31:0] span;
		span = to * (cc + 2) + 4;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 23);
			case ($urandom_range(0, 9))
				0: now_t = now_t + $urandom_range(0, span);
				1: now_t = now_t + $urandom_range(0, to + 2);
				default: now_t = now_t + $urandom_range(0, 3);
			endcase
			if ($urandom_range(0, 30) == 0) now_t = $urandom;
			send_item($urandom_range(0, 4) == 0 ? KIND_TICK : ipbm_pkg::KIND_PACKET, now_t,
				$urandom_range(0, 15) == 0 ? 48'({$urandom, $urandom}) : mac_pool[k],
				k % 3 == 0 ? 8'hFF : 8'(k % 3),
				$urandom_range(0, 4) != 0,
				$urandom_range(0, 7) == 0 ? $urandom : ip_pool[$urandom_range(0, 11)]);
		end
	endtask

	initial begin
		#10000000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = 1'b0;
		now = '0;
		mac = '0;
		port = '0;
		ip_present = 1'b0;
		host_ip = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		foreach (mac_pool[i]) mac_pool[i] = 48'({$urandom, $urandom});
		foreach (ip_pool[i]) ip_pool[i] = $urandom;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, ip list refresh and overflow, aging, table overflow
		send_item(ipbm_pkg::KIND_PACKET, 32'd0, '1, 8'hFF, 1'b1, '1);
		send_item(ipbm_pkg::KIND_PACKET, 32'd0, '0, 8'h00, 1'b1, '0);
		send_item(ipbm_pkg::KIND_PACKET, 32'd1, '0, 8'h00, 1'b1, 32'h1);
		send_item(ipbm_pkg::KIND_PACKET, 32'd2, '0, 8'h00, 1'b1, 32'h1);
		send_item(ipbm_pkg::KIND_PACKET, 32'd3, '0, 8'h00, 1'b1, 32'h2);
		send_item(ipbm_pkg::KIND_PACKET, 32'd4, '0, 8'h00, 1'b1, 32'h3);
		send_item(ipbm_pkg::KIND_PACKET, 32'd5, '0, 8'h00, 1'b1, 32'h4);
		send_item(ipbm_pkg::KIND_PACKET, 32'd6, '0, 8'h00, 1'b0, 32'h5);
		send_item(KIND_TICK, 32'd100, '1, 8'hFF, 1'b1, 32'h6);
		for (int i = 0; i < 15; i++)
			send_item(ipbm_pkg::KIND_PACKET, 32'd101, mac_pool[i], 8'(i), 1'b1,
				ip_pool[i % 12]);
		send_item(KIND_TICK, 32'hFFFF_FFFF, '0, 8'h00, 1'b0, '0);

		now_t = 32'd200;
		settle_and_config(16'd5, 16'd3, 16'd1);
		random_phase(80, 16'd5, 8'd3);
		settle_and_config(16'd1, 16'd1, 16'd0);
		random_phase(70, 16'd1, 8'd1);
		settle_and_config(16'hFFFF, 16'd255, 16'd1);
		random_phase(70, 16'hFFFF, 8'd255);
		settle_and_config(16'd0, 16'd0, 16'd1);
		random_phase(40, 16'd0, 8'd0);
		settle_and_config(16'd60, 16'd10, 16'd1);
		random_phase(60, 16'd60, 8'd10);
		settle_and_config(16'd2, 16'd2, 16'd1);
		quiet = 1;
		random_phase(65, 16'd2, 8'd2);
		in_valid <= 1'b0;

		while (sb.events_due.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (sb.errors == 0 && sb.events_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/ipbm_pkg.sv
rtl/ipbm_ram.sv
rtl/mac_ip_binding_monitor.sv
tb/tb_mac_ip_binding_monitor.sv
